>>> src/hpmes_pkg.sv
// ----------------------------------------------------------------------------
// hpmes_pkg
// Shared constants, types and controller states of the heap pass sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package hpmes_pkg;

    // capacity of the element store
    localparam int MAX_ELEMS = 32;
    localparam int DATA_W    = 32;
    localparam int SLOT_W    = 6;
    localparam int ADDR_W    = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ELEMS + 1);

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [DATA_W-1:0] t_data;

    // sequencer states
    typedef enum logic [3:0] {
        S_LOAD,
        S_PASS_INIT,
        S_RD_CH,
        S_CMP,
        S_PAR,
        S_WR_CH,
        S_ROOT_RD,
        S_ROOT_WR,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

>>> src/hpmes_in_if.sv
// ----------------------------------------------------------------------------
// hpmes_in_if
// Request channel carrying one element to be sorted and its last marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpmes_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [hpmes_pkg::DATA_W-1:0] value;
    logic                             is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

`default_nettype wire

>>> src/hpmes_out_if.sv
// ----------------------------------------------------------------------------
// hpmes_out_if
// Result channel carrying one extracted value with its slot and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpmes_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [hpmes_pkg::DATA_W-1:0] sorted_value;
    logic [hpmes_pkg::SLOT_W-1:0]        slot;
    logic                                dropped;
    logic                                end_of_run;

    modport source (output valid, output sorted_value, output slot,
                    output dropped, output end_of_run, input ready);
    modport sink   (input valid, input sorted_value, input slot,
                    input dropped, input end_of_run, output ready);
endinterface

`default_nettype wire

>>> src/heap_pass_max_extract_sorter.sv
// ----------------------------------------------------------------------------
// heap_pass_max_extract_sorter
// Collects signed values into a RAM and emits them largest first using
// repeated bottom-up heap passes.
// ----------------------------------------------------------------------------
// usage:
//   i_req takes one element per cycle while loading; an element with
//   is_last set closes the set and starts the sort. Elements that arrive
//   with the store full are discarded and every result of that set carries
//   dropped. i_req is held off while sorting.
//   o_res gives one result per stored element, largest first, with slot
//   equal to the remaining live count and end_of_run on the final one.
// extraction:
//   each extraction runs a bottom-up pass over the parents of the n live
//   elements, then moves the root out. A parent step reads both children,
//   reads the parent, decides and, for a swap, spends a further step on the
//   second write, since the element RAM has a single write port.
// reset and stall:
//   reset empties the set and drops a pending result. A result waits in
//   the output register; while it is not taken the sequencer holds in its
//   emit step, and the next set may start loading once the last result is
//   in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_pass_max_extract_sorter (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hpmes_in_if.sink    i_req,
    hpmes_out_if.source o_res
);

    localparam int CW = hpmes_pkg::CNT_W;
    localparam int AW = hpmes_pkg::ADDR_W;

    hpmes_pkg::t_state r_state, n_state;
    hpmes_pkg::t_cnt   r_cnt, n_cnt;
    hpmes_pkg::t_cnt   r_p, n_p;
    logic              r_ovf, n_ovf;
    hpmes_pkg::t_addr  r_pick_idx, n_pick_idx;
    hpmes_pkg::t_data  r_pick_val, n_pick_val;
    hpmes_pkg::t_data  r_hold, n_hold;

    logic                              r_out_valid, n_out_valid;
    hpmes_pkg::t_data                  r_out_val, n_out_val;
    logic [hpmes_pkg::SLOT_W-1:0]      r_out_slot, n_out_slot;
    logic                              r_out_drop, n_out_drop;
    logic                              r_out_end, n_out_end;

    logic             ram_we;
    hpmes_pkg::t_addr ram_wr_addr;
    hpmes_pkg::t_data ram_wr_data;
    hpmes_pkg::t_addr ram_rd_addr_a, ram_rd_addr_b;
    hpmes_pkg::t_data ram_rd_data_a, ram_rd_data_b;

    logic          in_accept;
    logic          out_free;
    logic [CW:0]   child_l, child_r;
    hpmes_pkg::t_cnt par_idx;
    hpmes_pkg::t_cnt last_idx;
    logic          take_right;
    logic          do_swap;
    logic          in_ready;

    // element store
    hpmes_ram #(
        .WIDTH (hpmes_pkg::DATA_W),
        .DEPTH (hpmes_pkg::MAX_ELEMS)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (ram_we),
        .i_wr_addr   (ram_wr_addr),
        .i_wr_data   (ram_wr_data),
        .i_rd_addr_a (ram_rd_addr_a),
        .o_rd_data_a (ram_rd_data_a),
        .i_rd_addr_b (ram_rd_addr_b),
        .o_rd_data_b (ram_rd_data_b)
    );

    // handshake and index arithmetic
    assign in_ready   = (r_state == hpmes_pkg::S_LOAD);
    assign in_accept  = i_req.valid && in_ready;
    assign out_free   = !r_out_valid || o_res.ready;
    assign child_r    = {r_p, 1'b0};
    assign child_l    = child_r - (CW+1)'(1);
    assign par_idx    = r_p - CW'(1);
    assign last_idx   = r_cnt - CW'(1);
    assign take_right = (child_r < {1'b0, r_cnt}) &&
                        !($signed(ram_rd_data_a) > $signed(ram_rd_data_b));
    assign do_swap    = $signed(ram_rd_data_a) < $signed(r_pick_val);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hpmes_pkg::S_LOAD: begin
                if (in_accept && i_req.is_last) begin
                    n_state = hpmes_pkg::S_PASS_INIT;
                end
            end
            hpmes_pkg::S_PASS_INIT: begin
                if ((r_cnt >> 1) == '0) begin
                    n_state = hpmes_pkg::S_ROOT_RD;
                end else begin
                    n_state = hpmes_pkg::S_RD_CH;
                end
            end
            hpmes_pkg::S_RD_CH: n_state = hpmes_pkg::S_CMP;
            hpmes_pkg::S_CMP:   n_state = hpmes_pkg::S_PAR;
            hpmes_pkg::S_PAR: begin
                if (do_swap) begin
                    n_state = hpmes_pkg::S_WR_CH;
                end else if (r_p == CW'(1)) begin
                    n_state = hpmes_pkg::S_ROOT_RD;
                end else begin
                    n_state = hpmes_pkg::S_RD_CH;
                end
            end
            hpmes_pkg::S_WR_CH: begin
                if (r_p == CW'(1)) begin
                    n_state = hpmes_pkg::S_ROOT_RD;
                end else begin
                    n_state = hpmes_pkg::S_RD_CH;
                end
            end
            hpmes_pkg::S_ROOT_RD: n_state = hpmes_pkg::S_ROOT_WR;
            hpmes_pkg::S_ROOT_WR: n_state = hpmes_pkg::S_EMIT;
            hpmes_pkg::S_EMIT: begin
                if (out_free) begin
                    if (last_idx == '0) begin
                        n_state = hpmes_pkg::S_LOAD;
                    end else begin
                        n_state = hpmes_pkg::S_PASS_INIT;
                    end
                end
            end
            default: n_state = hpmes_pkg::S_LOAD;
        endcase
    end

    // memory control and datapath
    always_comb begin
        n_cnt         = r_cnt;
        n_p           = r_p;
        n_ovf         = r_ovf;
        n_pick_idx    = r_pick_idx;
        n_pick_val    = r_pick_val;
        n_hold        = r_hold;
        n_out_valid   = r_out_valid && !o_res.ready;
        n_out_val     = r_out_val;
        n_out_slot    = r_out_slot;
        n_out_drop    = r_out_drop;
        n_out_end     = r_out_end;
        ram_we        = 1'b0;
        ram_wr_addr   = '0;
        ram_wr_data   = r_hold;
        ram_rd_addr_a = '0;
        ram_rd_addr_b = '0;
        case (r_state)
            // store a request or note the overflow
            hpmes_pkg::S_LOAD: begin
                if (in_accept) begin
                    if (r_cnt < CW'(hpmes_pkg::MAX_ELEMS)) begin
                        ram_we      = 1'b1;
                        ram_wr_addr = r_cnt[AW-1:0];
                        ram_wr_data = i_req.value;
                        n_cnt       = r_cnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            // start at the last parent
            hpmes_pkg::S_PASS_INIT: begin
                n_p = r_cnt >> 1;
            end
            // fetch both children
            hpmes_pkg::S_RD_CH: begin
                ram_rd_addr_a = child_l[AW-1:0];
                ram_rd_addr_b = child_r[AW-1:0];
            end
            // pick the larger child, fetch the parent
            hpmes_pkg::S_CMP: begin
                if (take_right) begin
                    n_pick_idx = child_r[AW-1:0];
                    n_pick_val = ram_rd_data_b;
                end else begin
                    n_pick_idx = child_l[AW-1:0];
                    n_pick_val = ram_rd_data_a;
                end
                ram_rd_addr_a = par_idx[AW-1:0];
            end
            // first half of a swap, or move on
            hpmes_pkg::S_PAR: begin
                if (do_swap) begin
                    ram_we      = 1'b1;
                    ram_wr_addr = par_idx[AW-1:0];
                    ram_wr_data = r_pick_val;
                    n_hold      = ram_rd_data_a;
                end else begin
                    n_p = r_p - CW'(1);
                end
            end
            // second half of a swap
            hpmes_pkg::S_WR_CH: begin
                ram_we      = 1'b1;
                ram_wr_addr = r_pick_idx;
                ram_wr_data = r_hold;
                n_p         = r_p - CW'(1);
            end
            // fetch root and last live element
            hpmes_pkg::S_ROOT_RD: begin
                ram_rd_addr_a = '0;
                ram_rd_addr_b = last_idx[AW-1:0];
            end
            hpmes_pkg::S_ROOT_WR: begin
                ram_we      = 1'b1;
                ram_wr_addr = '0;
                ram_wr_data = ram_rd_data_b;
                n_hold      = ram_rd_data_a;
            end
            // park the maximum past the live region and emit it
            hpmes_pkg::S_EMIT: begin
                if (out_free) begin
                    ram_we      = 1'b1;
                    ram_wr_addr = last_idx[AW-1:0];
                    ram_wr_data = r_hold;
                    n_out_valid = 1'b1;
                    n_out_val   = r_hold;
                    n_out_slot  = hpmes_pkg::SLOT_W'(last_idx);
                    n_out_drop  = r_ovf;
                    n_out_end   = (last_idx == '0);
                    n_cnt       = last_idx;
                    if (last_idx == '0) begin
                        n_ovf = 1'b0;
                        n_p   = '0;
                    end
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hpmes_pkg::S_LOAD;
            r_cnt       <= '0;
            r_p         <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_p         <= n_p;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pick_idx <= n_pick_idx;
        r_pick_val <= n_pick_val;
        r_hold     <= n_hold;
        r_out_val  <= n_out_val;
        r_out_slot <= n_out_slot;
        r_out_drop <= n_out_drop;
        r_out_end  <= n_out_end;
    end

    // ports
    assign i_req.ready        = in_ready;
    assign o_res.valid        = r_out_valid;
    assign o_res.sorted_value = r_out_val;
    assign o_res.slot         = r_out_slot;
    assign o_res.dropped      = r_out_drop;
    assign o_res.end_of_run   = r_out_end;

    // live count never passes capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(hpmes_pkg::MAX_ELEMS))
        else $error("live count beyond capacity");

    // a parent step always has a left child inside the live region
    a_parent_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hpmes_pkg::S_RD_CH) |-> (r_p != '0) && (child_r <= {1'b0, r_cnt}))
        else $error("parent step outside live region");

    // the final result returns the block to an empty set
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hpmes_pkg::S_EMIT && out_free && last_idx == '0) |=>
        (r_state == hpmes_pkg::S_LOAD && r_cnt == '0 && !r_ovf && r_out_end))
        else $error("set not cleared after final result");

endmodule

`default_nettype wire

>>> src/hpmes_ram.sv
// ----------------------------------------------------------------------------
// hpmes_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hpmes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                         i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr_a,
    output logic      [WIDTH-1:0]                         o_rd_data_a,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr_b,
    output logic      [WIDTH-1:0]                         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

`default_nettype wire

>>> bench/heap_pass_max_extract_sorter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_pass_max_extract_sorter_tb
// Sends sets of signed elements to the heap pass sorter and checks every
// extracted value, slot and flag against a cycle-free model of the
// extraction passes. Covers edge values, equal children, full and
// overflowing sets, random stalls on both channels and a long output stall.
// ----------------------------------------------------------------------------

module heap_pass_max_extract_sorter_tb;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_ITEMS  = 85;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 2000000;

    typedef logic signed [hpmes_pkg::DATA_W-1:0] t_elem;
    typedef t_elem t_elem_q[$];

    localparam t_elem ELEM_MAX = 32'sh7FFF_FFFF;
    localparam t_elem ELEM_MIN = 32'sh8000_0000;

    // one extracted value as it leaves the block
    typedef struct packed {
        logic signed [hpmes_pkg::DATA_W-1:0] value;
        logic [hpmes_pkg::SLOT_W-1:0]        slot;
        logic                                dropped;
        logic                                end_of_run;
    } t_sorted;

    // ------------------------------------------------------------------------
    // model of the element store and the expected extraction order
    // ------------------------------------------------------------------------
    class sorted_output_board;
        t_elem   elem_mem[hpmes_pkg::MAX_ELEMS];
        int      live;
        bit      overflow;
        t_sorted pending_sorted[$];
        int      fault_count;

        function new();
            live        = 0;
            overflow    = 1'b0;
            fault_count = 0;
        endfunction

        // store an accepted element, run the extraction passes on the last one
        function void note_element(t_elem v, logic last);
            int      n;
            int      par;
            int      pick;
            t_elem   tmp;
            t_sorted res;
            if (live < hpmes_pkg::MAX_ELEMS) begin
                elem_mem[live] = v;
                live++;
            end else begin
                overflow = 1'b1;
            end
            if (!last) return;
            while (live > 0) begin
                n = live;
                // bottom-up pass from the last parent to the root
                for (par = n / 2 - 1; par >= 0; par--) begin
                    pick = 2 * par + 1;
                    // equal children: the right one is compared
                    if (pick + 1 < n && !(elem_mem[pick] > elem_mem[pick + 1]))
                        pick = pick + 1;
                    if (elem_mem[par] < elem_mem[pick]) begin
                        tmp            = elem_mem[par];
                        elem_mem[par]  = elem_mem[pick];
                        elem_mem[pick] = tmp;
                    end
                end
                // root goes past the end of the live region
                tmp             = elem_mem[0];
                elem_mem[0]     = elem_mem[n - 1];
                elem_mem[n - 1] = tmp;
                live            = n - 1;
                res.value      = elem_mem[live];
                res.slot       = hpmes_pkg::SLOT_W'(live);
                res.dropped    = overflow;
                res.end_of_run = (live == 0);
                pending_sorted.push_back(res);
            end
            live     = 0;
            overflow = 1'b0;
        endfunction

        // compare one result with the oldest expectation
        function void check_sorted(t_sorted got);
            t_sorted exp_res;
            if (pending_sorted.size() == 0) begin
                $display("%0t: unexpected result, actual value %0d slot %0d",
                         $time, got.value, got.slot);
                fault_count++;
                return;
            end
            exp_res = pending_sorted.pop_front();
            if (got.value !== exp_res.value) begin
                $display("%0t: sorted_value mismatch, expected %0d actual %0d",
                         $time, exp_res.value, got.value);
                fault_count++;
            end
            if (got.slot !== exp_res.slot) begin
                $display("%0t: slot mismatch, expected %0d actual %0d",
                         $time, exp_res.slot, got.slot);
                fault_count++;
            end
            if (got.dropped !== exp_res.dropped) begin
                $display("%0t: dropped mismatch, expected %0b actual %0b",
                         $time, exp_res.dropped, got.dropped);
                fault_count++;
            end
            if (got.end_of_run !== exp_res.end_of_run) begin
                $display("%0t: end_of_run mismatch, expected %0b actual %0b",
                         $time, exp_res.end_of_run, got.end_of_run);
                fault_count++;
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    hpmes_in_if  req_if();
    hpmes_out_if res_if();

    sorted_output_board board = new();

    bit idle_on      = 1'b1;
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int stall_left   = 0;
    int cycle_count  = 0;

    heap_pass_max_extract_sorter u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    // clock
    always #CLK_HALF clk = ~clk;

    // known values on every input from time zero
    initial begin
        req_if.valid   = 1'b0;
        req_if.value   = '0;
        req_if.is_last = 1'b0;
        res_if.ready   = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // accepted requests and results, requests first
    always @(posedge clk) begin
        if (rst_n) begin
            if (req_if.valid && req_if.ready)
                board.note_element(req_if.value, req_if.is_last);
            if (res_if.valid && res_if.ready)
                board.check_sorted({res_if.sorted_value, res_if.slot,
                                    res_if.dropped, res_if.end_of_run});
        end
    end

    // result side: long hold on request, otherwise random stall bursts
    always @(negedge clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            res_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // mix of edge values, small values that repeat and full-range values
    function automatic t_elem_q random_set(int n);
        t_elem_q elems;
        repeat (n) begin
            case ($urandom_range(0, 5))
                0:       elems.push_back(ELEM_MIN);
                1:       elems.push_back(ELEM_MAX);
                2, 3:    elems.push_back(t_elem'($urandom_range(0, 7)) - 3);
                default: elems.push_back(t_elem'($urandom));
            endcase
        end
        return elems;
    endfunction

    // one request, with an optional gap in front of it
    task automatic send_element(input t_elem v, input logic last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge clk);
            req_if.valid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
        end
        @(negedge clk);
        req_if.valid   <= 1'b1;
        req_if.value   <= v;
        req_if.is_last <= last;
        do @(posedge clk); while (req_if.ready !== 1'b1);
    endtask

    // a whole set, last marker on the final element
    task automatic send_set(input t_elem_q elems);
        foreach (elems[i])
            send_element(elems[i], i == elems.size() - 1);
    endtask

    // withdraw the request and wait for every expected result
    task automatic wait_drained();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (board.pending_sorted.size() != 0) @(posedge clk);
    endtask

    // stimulus
    initial begin
        t_elem_q elems;
        int      sent;
        int      n;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single element sets at both extremes
        elems = {ELEM_MAX};
        send_set(elems);
        elems = {ELEM_MIN};
        send_set(elems);
        // equal children under a smaller root
        elems = {32'sd5, 32'sd7, 32'sd7};
        send_set(elems);
        elems = {ELEM_MIN, ELEM_MAX, 32'sd0, -32'sd1, 32'sd1};
        send_set(elems);
        elems = {-32'sd2, -32'sd2, -32'sd2, -32'sd2};
        send_set(elems);
        elems = {32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd6};
        send_set(elems);

        // sender pause until every result is out
        wait_drained();

        // exactly full store
        sent = 0;
        send_set(random_set(hpmes_pkg::MAX_ELEMS));
        sent += hpmes_pkg::MAX_ELEMS;

        // long output stall while two more sets are offered
        hold_request = 1'b1;
        send_set(random_set(5));
        send_set(random_set(3));
        sent += 8;

        // overflow: a dropped plain element, then a dropped last one
        send_set(random_set(hpmes_pkg::MAX_ELEMS + 2));
        sent += hpmes_pkg::MAX_ELEMS + 2;
        wait_drained();

        // random small sets, no idling toward the end
        while (sent < RANDOM_ITEMS) begin
            if (sent > RANDOM_ITEMS * 3 / 4)
                idle_on = 1'b0;
            n = $urandom_range(1, 8);
            send_set(random_set(n));
            sent += n;
        end
        idle_on = 1'b0;
        @(negedge clk);
        req_if.valid <= 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
